>>> sv/i2a_pkg.sv
// Shared constants, types and helpers for the integer-to-ASCII converter.
`default_nettype none
package i2a_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DIG_DEPTH   = 10;
    localparam int DIG_IDX_W   = $clog2(DIG_DEPTH);

    // floor(v / 10) == (v * RECIP10) >> RECIP_SHIFT for every 32-bit v
    localparam logic [VALUE_WIDTH-1:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int                     RECIP_SHIFT = 35;

    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h61;
    localparam logic [6:0] CH_MINUS = 7'h2D;

    localparam logic [1:0] KIND_SDEC = 2'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_FIX,
        ST_EMIT
    } i2a_state_t;

    function automatic logic [6:0] digit_ascii(input logic [3:0] d);
        logic [6:0] r;
        if (d < 4'd10)
            r = CH_ZERO + {3'b000, d};
        else
            r = CH_A + {3'b000, d} - 7'd10;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> sv/integer_to_ascii_digits.sv
// Top level: converts a 32-bit number to ASCII decimal or hex text.
//
// Input channel (s_*): one beat carries the number in s_tdata and the mode
// in s_tuser (0 signed decimal, 1 unsigned decimal, 2 or 3 lowercase hex).
// Output channel (m_*): one beat per character, most significant first, with
// a leading '-' for a negative signed value; m_tlast marks the final one.
// Zero gives the single character '0'.
// Flow: digits come out of one shared divide unit. A decimal digit takes a
// reciprocal multiply step, then a remainder fix-up step; a hex digit takes
// only the fix-up step. After that the characters leave at one per cycle
// while m_tready is high. s_tready is high only while no number is in
// flight. A stalled receiver simply holds the current character; nothing is
// lost. Reset drops any number in progress and returns to the ready state.
`default_nettype none
module integer_to_ascii_digits (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] number
    input  wire logic [1:0]  s_tuser,   // [1:0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [6:0] digit_char, [7] zero
    output logic             m_tlast    // last_char
);
    import i2a_pkg::*;

    i2a_state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] mag_reg;
    logic                   hex_reg;
    logic                   minus_reg;
    logic [DIG_IDX_W-1:0]   cnt_reg;
    logic [DIG_IDX_W-1:0]   idx_reg;
    logic [3:0]             digits_reg [DIG_DEPTH];

    logic [VALUE_WIDTH-1:0] in_mag;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] quot;
    logic [3:0]             digit;
    logic                   unit_load;
    logic                   s_beat;
    logic                   m_beat;

    assign in_neg = (s_tuser == KIND_SDEC) && s_tdata[VALUE_WIDTH-1];
    // two's complement negate; the most negative value maps to 2^31 itself
    assign in_mag = in_neg ? (~s_tdata + 32'd1) : s_tdata;

    assign s_beat = s_tvalid && s_tready;
    assign m_beat = m_tvalid && m_tready;

    i2a_digit_unit u_unit (
        .clk   (clk),
        .load  (unit_load),
        .hex   (hex_reg),
        .mag   (mag_reg),
        .quot  (quot),
        .digit (digit)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_beat)
                    state_next = s_tuser[1] ? ST_FIX : ST_MUL;
            end
            ST_MUL:
                state_next = ST_FIX;
            ST_FIX:
            begin
                if (quot == '0)
                    state_next = ST_EMIT;
                else
                    state_next = hex_reg ? ST_FIX : ST_MUL;
            end
            ST_EMIT:
            begin
                if (m_beat && !minus_reg && idx_reg == '0)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        unit_load = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready  = 1'b1;
            ST_MUL:  unit_load = 1'b1;
            ST_FIX:  ;
            ST_EMIT: m_tvalid  = 1'b1;
            default: ;
        endcase
    end

    assign m_tdata = {1'b0, minus_reg ? CH_MINUS : digit_ascii(digits_reg[idx_reg])};
    assign m_tlast = !minus_reg && (idx_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            minus_reg <= 1'b0;
            hex_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_beat)
                    begin
                        hex_reg   <= s_tuser[1];
                        minus_reg <= in_neg;
                        cnt_reg   <= '0;
                    end
                end
                ST_MUL: ;
                ST_FIX:
                begin
                    idx_reg <= cnt_reg;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                ST_EMIT:
                begin
                    if (m_beat)
                    begin
                        if (minus_reg)
                            minus_reg <= 1'b0;
                        else if (idx_reg != '0)
                            idx_reg <= idx_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_beat)
            mag_reg <= in_mag;
        else if (state_reg == ST_FIX)
        begin
            mag_reg             <= quot;
            digits_reg[cnt_reg] <= digit;
        end
    end

endmodule
`default_nettype wire

>>> sv/i2a_digit_unit.sv
// Shared digit unit: one quotient/remainder step by ten or by sixteen.
`default_nettype none
module i2a_digit_unit (
    input  wire logic                           clk,
    input  wire logic                           load,   // capture reciprocal product
    input  wire logic                           hex,
    input  wire logic [i2a_pkg::VALUE_WIDTH-1:0] mag,
    output logic      [i2a_pkg::VALUE_WIDTH-1:0] quot,
    output logic      [3:0]                      digit
);
    import i2a_pkg::*;

    localparam int QW = 2 * VALUE_WIDTH - RECIP_SHIFT;

    logic [2*VALUE_WIDTH-1:0] prod_reg;
    logic [2*VALUE_WIDTH-1:0] prod_next;
    logic [VALUE_WIDTH-1:0]   quot_dec;
    logic [VALUE_WIDTH-1:0]   times10;
    logic [VALUE_WIDTH-1:0]   rem_dec;

    assign prod_next = {{VALUE_WIDTH{1'b0}}, mag} * {{VALUE_WIDTH{1'b0}}, RECIP10};

    always_ff @(posedge clk)
    begin
        if (load)
            prod_reg <= prod_next;
    end

    // mag is held steady between the load cycle and this one
    assign quot_dec = {{(VALUE_WIDTH - QW){1'b0}}, prod_reg[2*VALUE_WIDTH-1:RECIP_SHIFT]};
    assign times10  = (quot_dec << 3) + (quot_dec << 1);
    assign rem_dec  = mag - times10;

    always_comb
    begin
        if (hex)
        begin
            quot  = mag >> 4;
            digit = mag[3:0];
        end
        else
        begin
            quot  = quot_dec;
            digit = rem_dec[3:0];
        end
    end

endmodule
`default_nettype wire
